[rtl/core/bpq_pkg.sv]
// Shared types and codes for the bounded priority queue.
`default_nettype none
package bpq_pkg;

  localparam int CNT_W = 5;
  localparam int VAL_W = 32;
  localparam int IDX_W = 16;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic report;
    logic cfg_write;
  } dp_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] min_value;
    logic [IDX_W-1:0]        min_index;
    logic signed [VAL_W-1:0] max_value;
    logic [IDX_W-1:0]        max_index;
    logic                    is_empty;
    logic                    is_full;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/bpq_if.sv]
// Valid/ready channel interfaces: request, response and capacity write.
`default_nettype none
interface bpq_req_if;
  logic                                valid;
  logic                                ready;
  logic [bpq_pkg::OP_W-1:0]            op;
  logic [bpq_pkg::IDX_W-1:0]           item_index;
  logic signed [bpq_pkg::VAL_W-1:0]    item_value;

  modport source (output valid, op, item_index, item_value, input ready);
  modport sink (input valid, op, item_index, item_value, output ready);
endinterface

interface bpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bpq_pkg::ST_W-1:0]            status;
  logic [bpq_pkg::CNT_W-1:0]           count;
  logic signed [bpq_pkg::VAL_W-1:0]    min_value;
  logic [bpq_pkg::IDX_W-1:0]           min_index;
  logic signed [bpq_pkg::VAL_W-1:0]    max_value;
  logic [bpq_pkg::IDX_W-1:0]           max_index;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, status, count, min_value, min_index, max_value,
                  max_index, is_empty, is_full, input ready);
  modport sink (input valid, status, count, min_value, min_index, max_value,
                max_index, is_empty, is_full, output ready);
endinterface

interface bpq_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bpq_pkg::CNT_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface
`default_nettype wire

[rtl/core/bpq_ctrl.sv]
// Controller state machine: handshakes and sequencing of the datapath.
`default_nettype none
module bpq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output bpq_pkg::dp_cmd_t       cmd
);
  import bpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  // config takes precedence over a request in the same cycle
  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    cmd           = '0;
    cmd.cfg_write = cfg_valid && cfg_ready;
    cmd.capture   = req_valid && req_ready;
    cmd.execute   = (state == S_EXEC);
    cmd.report    = (state == S_REPORT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // a new result takes the slot as the previous one leaves
      if (cmd.report) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/bpq_dp.sv]
// Datapath: sorted cell array with parallel compare and shift, result register.
`default_nettype none
module bpq_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bpq_pkg::dp_cmd_t                 cmd,
  input  wire logic [bpq_pkg::OP_W-1:0]         op,
  input  wire logic [bpq_pkg::IDX_W-1:0]        item_index,
  input  wire logic signed [bpq_pkg::VAL_W-1:0] item_value,
  input  wire logic [bpq_pkg::CNT_W-1:0]        cfg_capacity,
  output bpq_pkg::result_t                      result
);
  import bpq_pkg::*;

  localparam int CAP_MAX   = (DEPTH < (2 ** CNT_W) - 1) ? DEPTH : (2 ** CNT_W) - 1;
  localparam int CAP_RESET = (16 < CAP_MAX) ? 16 : CAP_MAX;

  function automatic logic sorts_after(entry_t a, entry_t b);
    logic res;
    if (a.value != b.value) begin
      res = (a.value > b.value);
    end else begin
      res = (a.index > b.index);
    end
    return res;
  endfunction

  entry_t           cells [DEPTH];
  entry_t           cells_next [DEPTH];
  entry_t           new_entry;
  op_t              op_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] cap_clamped;
  status_t          status;
  status_t          status_next;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] after;
  logic             full;
  logic             reject;
  entry_t           last_entry;

  // clamp written capacity to 1..CAP_MAX
  always_comb begin
    if (cfg_capacity == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (int'(cfg_capacity) > CAP_MAX) begin
      cap_clamped = CNT_W'(CAP_MAX);
    end else begin
      cap_clamped = cfg_capacity;
    end
  end

  // per-cell compare against the new item; thermometer over valid cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i]    = (i < int'(count)) && sorts_after(cells[i], new_entry);
      after[i] = (i >= int'(count)) || gt[i];
    end
  end

  assign full   = (count == cap_eff);
  assign reject = full && !(|gt);

  always_comb begin
    cells_next  = cells;
    count_next  = count;
    status_next = ST_OK;
    case (op_q)
      OP_ENQ: begin
        if (reject) begin
          status_next = ST_FULL;
        end else begin
          if (after[0]) begin
            cells_next[0] = new_entry;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (after[i]) begin
              cells_next[i] = after[i-1] ? cells[i-1] : new_entry;
            end
          end
          // when full, the largest falls off the end of the valid range
          count_next = full ? count : count + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            cells_next[i] = cells[i+1];
          end
          count_next = count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // tail select for the largest entry
  always_comb begin
    last_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(count) == i + 1) begin
        last_entry = cells[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cap_eff <= CNT_W'(CAP_RESET);
    end else if (cmd.cfg_write) begin
      count   <= '0;
      cap_eff <= cap_clamped;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q            <= op_t'(op);
      new_entry.value <= item_value;
      new_entry.index <= item_index;
    end
    if (cmd.execute) begin
      cells  <= cells_next;
      status <= status_next;
    end
    if (cmd.report) begin
      result.status    <= status;
      result.count     <= count;
      result.is_empty  <= (count == '0);
      result.is_full   <= (count == cap_eff);
      if (count == '0) begin
        result.min_value <= '0;
        result.min_index <= '0;
        result.max_value <= '0;
        result.max_index <= '0;
      end else begin
        result.min_value <= cells[0].value;
        result.min_index <= cells[0].index;
        result.max_value <= last_entry.value;
        result.max_index <= last_entry.index;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/bounded_priority_queue.sv]
// Top level of the bounded priority queue: controller, datapath, ports.
// Sequencing: an accepted request updates the cell array (execute), then
//   loads the result register (report), which waits while a previous response is not yet taken.
// Requests are taken one at a time; the controller sequences one item
//   through the cell array update and the result register before the next.
// Reset (rst, synchronous, active high): queue empty, capacity 16 (limited
//   to DEPTH), no response pending. Stored entries are not cleared.
`default_nettype none
module bounded_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  bpq_req_if.sink   req,
  bpq_rsp_if.source rsp,
  bpq_cfg_if.sink   cfg
);
  import bpq_pkg::*;

  dp_cmd_t cmd;
  result_t result;

  // Sequencer: idle -> execute -> report. A capacity write is taken only
  // when idle and wins over a request offered in the same cycle.
  bpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Sorted cells: every cell compares itself against the new item in
  // parallel, then shifts right (insert) or left (dequeue) in the execute state.
  bpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .op           (req.op),
    .item_index   (req.item_index),
    .item_value   (req.item_value),
    .cfg_capacity (cfg.capacity),
    .result       (result)
  );

  // Response payload straight from the result register
  assign rsp.status    = result.status;
  assign rsp.count     = result.count;
  assign rsp.min_value = result.min_value;
  assign rsp.min_index = result.min_index;
  assign rsp.max_value = result.max_value;
  assign rsp.max_index = result.max_index;
  assign rsp.is_empty  = result.is_empty;
  assign rsp.is_full   = result.is_full;

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.count == '0)))
    else $error("is_empty disagrees with count");

  // sorted order: smallest never above largest
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.is_empty) |-> (rsp.min_value <= rsp.max_value))
    else $error("min entry sorts above max entry");

  // a refused enqueue only happens on a full queue
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> rsp.is_full)
    else $error("full status on a queue that is not full");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

endmodule
`default_nettype wire
